>>> design/qvs_pkg.sv
// ----------------------------------------------------------------------------
// qvs_pkg
// Shared types, constants and the quadrature transition table for the
// quadrature volume stepper.
// ----------------------------------------------------------------------------
package qvs_pkg;

  // field and register widths
  localparam int unsigned SpcW     = 3;
  localparam int unsigned LimW     = 3;
  localparam int unsigned HoldW    = 10;
  localparam int unsigned PendW    = 4;
  localparam int unsigned AccW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  typedef logic [CfgIdxW-1:0]     cfg_idx_t;
  typedef logic [CfgDataW-1:0]    cfg_data_t;
  typedef logic signed [PendW-1:0] pend_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [HoldW-1:0]        hold_t;
  typedef logic signed [1:0]       dir_t;

  // configuration register indexes
  localparam cfg_idx_t RegStepsPerCmd = 2'd0;
  localparam cfg_idx_t RegPendLimit   = 2'd1;
  localparam cfg_idx_t RegHoldoff     = 2'd2;

  // configuration reset values
  localparam logic [SpcW-1:0] SpcReset  = 3'd2;
  localparam logic [LimW-1:0] LimReset  = 3'd4;
  localparam hold_t           HoldReset = 10'd50;

  // tick counter saturates here
  localparam hold_t HoldSat = 10'd1023;

  // transition decode: index is {previous A, previous B, current A, current B}
  function automatic dir_t step_dir(input logic [3:0] trans);
    dir_t d;
    unique case (trans)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default:                  d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> design/quadrature_volume_stepper.sv
// output: a result is registered and presented in the cycle after its sample is accepted
// throughput: one sample per cycle when not stalled; all decode and queue
//   logic sits between the state registers and the single output register
// reset: synchronous active-low rst_n restores the config defaults, clears
//   the phase, accumulator, queue and holdoff state and empties the output
// ----------------------------------------------------------------------------
// quadrature_volume_stepper
// Decodes quadrature encoder samples into queued volume up/down commands and
// issues them with a holdoff between attempts.
// ----------------------------------------------------------------------------
module quadrature_volume_stepper (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_phase_a,
  input  logic               in_phase_b,
  input  logic               in_inhibit,
  input  logic               in_link_up,
  input  logic               in_cmd_ready,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_cmd_valid,
  output logic               out_cmd_down,
  output qvs_pkg::pend_t     out_pending_count,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  qvs_pkg::cfg_idx_t  cfg_index,
  input  qvs_pkg::cfg_data_t cfg_data
);
  import qvs_pkg::*;

  // configuration registers
  logic [SpcW-1:0] spc_r;
  logic [LimW-1:0] lim_r;
  hold_t           hold_r;

  // tick state
  logic [1:0] last_r, last_nxt;
  logic       primed_r;
  acc_t       acc_r, acc_nxt;
  pend_t      pend_r, pend_nxt;
  hold_t      ticks_r, ticks_nxt;
  logic       tried_r, tried_nxt;

  // output register
  logic  out_valid_r;
  logic  cmd_valid_r, cmd_valid_nxt;
  logic  cmd_down_r, cmd_down_nxt;
  pend_t pend_out_r;

  logic in_accept;
  logic out_accept;

  // decode intermediates
  logic [1:0]        cur;
  logic              moved;
  dir_t              dir;
  logic signed [4:0] acc_step;
  logic signed [4:0] acc_ext;
  logic signed [4:0] spc_ext;
  logic signed [4:0] lim_ext;
  logic signed [4:0] pend_ext;
  pend_t             pend_dec;
  logic              holdoff_ok;

  // handshakes
  assign out_accept = out_valid_r && !out_stall;
  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_cmd_valid     = cmd_valid_r;
  assign out_cmd_down      = cmd_down_r;
  assign out_pending_count = pend_out_r;

  assign cur      = {in_phase_a, in_phase_b};
  assign moved    = primed_r && (cur != last_r);
  assign dir      = step_dir({last_r, cur});
  assign acc_ext  = 5'(acc_r);
  assign spc_ext  = signed'({2'b00, spc_r});
  assign lim_ext  = signed'({2'b00, lim_r});
  assign pend_ext = 5'(pend_r);

  // saturating tick count since the last attempt
  assign ticks_nxt = (ticks_r == HoldSat) ? ticks_r : ticks_r + hold_t'(1);

  // phase decode and step accumulation
  always_comb begin
    last_nxt = primed_r ? last_r : cur;
    acc_nxt  = acc_r;
    pend_dec = pend_r;
    acc_step = acc_ext;
    if (moved) begin
      last_nxt = cur;
      if (dir == 2'sd0) begin
        acc_nxt = '0;
      end else begin
        if ((acc_ext > 5'sd0 && dir < 2'sd0) || (acc_ext < 5'sd0 && dir > 2'sd0)) begin
          acc_step = 5'(dir);
        end else begin
          acc_step = acc_ext + 5'(dir);
        end
        acc_nxt = acc_step[AccW-1:0];
        if (acc_step >= spc_ext) begin
          if (pend_ext < lim_ext) pend_dec = pend_r + pend_t'(1);
          acc_nxt = '0;
        end else if (acc_step <= -spc_ext) begin
          if (pend_ext > -lim_ext) pend_dec = pend_r - pend_t'(1);
          acc_nxt = '0;
        end
      end
    end
  end

  assign holdoff_ok = !tried_r || (ticks_nxt >= hold_r);

  // pending queue handling and command attempt
  always_comb begin
    pend_nxt      = pend_dec;
    tried_nxt     = tried_r;
    cmd_valid_nxt = 1'b0;
    cmd_down_nxt  = 1'b0;
    if (pend_dec != '0) begin
      if (in_inhibit || !in_link_up) begin
        pend_nxt = '0;
      end else if (holdoff_ok) begin
        cmd_valid_nxt = 1'b1;
        tried_nxt     = 1'b1;
        if (pend_dec > 4'sd0) begin
          if (in_cmd_ready) pend_nxt = pend_dec - pend_t'(1);
        end else begin
          cmd_down_nxt = 1'b1;
          if (in_cmd_ready) pend_nxt = pend_dec + pend_t'(1);
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r  <= SpcReset;
      lim_r  <= LimReset;
      hold_r <= HoldReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegStepsPerCmd: spc_r  <= cfg_data[SpcW-1:0];
        RegPendLimit:   lim_r  <= cfg_data[LimW-1:0];
        RegHoldoff:     hold_r <= cfg_data[HoldW-1:0];
        default:        ;
      endcase
    end
  end

  // tick state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      primed_r <= 1'b0;
      acc_r    <= '0;
      pend_r   <= '0;
      ticks_r  <= '0;
      tried_r  <= 1'b0;
    end else if (in_accept) begin
      last_r   <= last_nxt;
      primed_r <= 1'b1;
      acc_r    <= acc_nxt;
      pend_r   <= pend_nxt;
      ticks_r  <= cmd_valid_nxt ? hold_t'(0) : ticks_nxt;
      tried_r  <= tried_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_valid_r <= cmd_valid_nxt;
      cmd_down_r  <= cmd_down_nxt;
      pend_out_r  <= pend_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a down command is only flagged together with an attempt
  a_down_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_cmd_down || out_cmd_valid))
    else $error("cmd_down without cmd_valid");

  // queue and accumulator never reach the most negative code
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 4'sb1000 && acc_r != 4'sb1000)
    else $error("pending or accumulator out of range");

  // an accepted sample always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted sample produced no result");

  // an attempt restarts the holdoff count
  a_attempt_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cmd_valid_nxt) |=> (ticks_r == '0 && tried_r))
    else $error("attempt did not restart holdoff");

  // the reported count matches the queue state
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (pend_out_r == pend_r))
    else $error("reported pending count differs from queue");
`endif

endmodule
